// File: hw/rtl/tffc_pkg.sv
`timescale 1ns / 1ps
// Types, constants and helper functions for the tagged float converter.
// Used by tffc_step and tagged_float_format_converter; no dependencies.
package tffc_pkg;

    localparam int NumSteps = 7;

    localparam logic [22:0]        Carry22    = 23'h400000;
    localparam logic [22:0]        Bit21      = 23'h200000;
    localparam logic [21:0]        MantSat    = 22'h3fffff;
    localparam logic signed [12:0] MinExp     = -13'sd31;
    localparam logic signed [12:0] MaxExp     = 13'sd31;
    localparam logic [4:0]         MaxShift   = 5'd22;
    localparam logic [2:0]         TagReset   = 3'd2;
    localparam logic               OpToWord   = 1'b0;
    localparam logic               OpFromWord = 1'b1;

    // one request on the input channel
    typedef struct packed {
        logic        opcode;
        logic [63:0] operand;
    } t_req;

    // one response on the output channel
    typedef struct packed {
        logic [63:0] result;
        logic        overflow;
    } t_rsp;

    // work carried down the pipeline
    typedef struct packed {
        logic               fin;    // result already final
        logic               raw;    // res is the response as it stands
        logic [63:0]        res;
        logic               ovf;
        logic               msign;
        logic               done;   // scaling finished, r and x settled
        logic [52:0]        m;
        logic signed [12:0] e;
        logic [4:0]         k;
        logic [22:0]        r;
        logic signed [12:0] x;
    } t_lane;

    // free bits above the rounded value
    function automatic logic [2:0] gaps_for(input logic [22:0] r);
        logic [4:0] top;
        top = r[20:16];
        priority if (top == 5'd0) return 3'd6;
        else if (top == 5'd1)     return 3'd5;
        else if (top < 5'd4)      return 3'd4;
        else if (top < 5'd8)      return 3'd3;
        else if (top < 5'd16)     return 3'd2;
        else                      return 3'd1;
    endfunction

    // assemble a tagged word, zero-extended to 64 bits
    function automatic logic [63:0] pack_word(input logic [21:0] mant,
                                              input logic signed [12:0] ex,
                                              input logic msign,
                                              input logic [2:0] tag);
        logic [31:0]        w;
        logic signed [12:0] nx;
        nx = -ex;
        w  = {msign, 1'b0, mant, 5'd0, tag};
        if (ex < 0) begin
            w[30]  = 1'b1;
            w[7:3] = nx[4:0];
        end else begin
            w[7:3] = ex[4:0];
        end
        return {32'd0, w};
    endfunction

endpackage

// File: hw/rtl/tagged_float_format_converter.sv
`timescale 1ns / 1ps
// Top level of the tagged float converter: decode, scaling pipeline, packing.
// Depends on tffc_pkg and tffc_step.
//
// Takes one request per cycle and returns one response per request, in order,
// after it passes one decode stage, seven rounding and shifting steps (one per
// stage) and one output stage that packs the word.
// Throughput is one request per cycle; the whole pipeline holds while the
// output is stalled. The tag register is sampled at the output stage and must
// be written only while the pipeline is empty.
module tagged_float_format_converter import tffc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_req       i_in,
    output logic       o_in_stall,
    output logic       o_out_valid,
    output t_rsp       o_out,
    input  logic       i_out_stall,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_data
);

    logic        r_tag;
    logic [2:0]  r_float_tag;
    logic        adv;
    logic        r_vld0;
    t_lane       r_lane0;
    t_lane       n_lane0;
    logic        vld [NumSteps+1];
    t_lane       lane [NumSteps+1];
    logic        r_out_vld;
    t_rsp        r_out;
    t_rsp        n_out;

    // decode fields
    logic        neg;
    logic [10:0] bexp;
    logic [51:0] frac;
    logic [31:0] w;
    logic [21:0] fmant;
    logic [4:0]  p;
    logic signed [12:0] fex;
    logic [10:0] fexp;
    logic [51:0] ffrac;
    logic signed [12:0] ee;

    assign adv        = !(r_out_vld && i_out_stall);
    assign o_in_stall = !adv;

    // hold the tag register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_float_tag <= TagReset;
        end else if (i_cfg_we) begin
            r_float_tag <= i_cfg_data;
        end
    end

    // decode the request and settle the special cases
    always_comb begin
        neg   = i_in.operand[63];
        bexp  = i_in.operand[62:52];
        frac  = i_in.operand[51:0];
        ee    = 13'(bexp) - 13'sd1022;
        w     = i_in.operand[31:0];
        fmant = w[29:8];
        fex   = w[30] ? -13'($unsigned(w[7:3])) : 13'($unsigned(w[7:3]));
        p     = 5'd0;
        for (int i = 0; i < 22; i++) begin
            if (fmant[i]) p = 5'(i);
        end
        ffrac = 52'({30'd0, fmant} << (6'd52 - {1'b0, p}));
        fexp  = 11'(13'(p) + fex + 13'sd1023);

        n_lane0       = '0;
        n_lane0.msign = neg;
        n_lane0.m     = {1'b1, frac};
        n_lane0.e     = ee;
        if (i_in.opcode == OpFromWord) begin
            n_lane0.fin = 1'b1;
            n_lane0.raw = 1'b1;
            n_lane0.res = (fmant == 22'd0) ? {w[31], 63'd0} : {w[31], fexp, ffrac};
        end else if (bexp == 11'h7ff) begin
            n_lane0.fin   = 1'b1;
            n_lane0.ovf   = 1'b1;
            n_lane0.msign = neg && (frac == 52'd0);
        end else if (bexp == 11'd0) begin
            n_lane0.fin   = 1'b1;
            n_lane0.msign = neg && (frac != 52'd0);
        end else if (ee <= -13'sd32) begin
            n_lane0.fin = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
        end else if (adv) begin
            r_vld0 <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_lane0 <= n_lane0;
            r_tag   <= i_in.opcode;
        end
    end

    assign vld[0]  = r_vld0;
    assign lane[0] = r_lane0;

    // scaling steps
    for (genvar s = 0; s < NumSteps; s++) begin : g_step
        tffc_step u_step (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (adv),
            .i_vld  (vld[s]),
            .i_lane (lane[s]),
            .o_vld  (vld[s+1]),
            .o_lane (lane[s+1])
        );
    end

    // pack the final word
    always_comb begin
        t_lane l;
        l = lane[NumSteps];
        n_out.overflow = l.ovf;
        n_out.result   = l.res;
        if (!l.fin) begin
            if (l.x > MaxExp) begin
                n_out.overflow = 1'b1;
                n_out.result   = pack_word(MantSat, MaxExp, l.msign, r_float_tag);
            end else begin
                n_out.result   = pack_word(l.r[21:0], l.x, l.msign, r_float_tag);
            end
        end else if (l.raw) begin
            n_out.result = l.res;
        end else if (l.ovf) begin
            n_out.result = pack_word(MantSat, MaxExp, l.msign, r_float_tag);
        end else begin
            n_out.result = pack_word(22'd0, 13'sd0, l.msign, r_float_tag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= vld[NumSteps];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    // stall back-pressure only comes from a waiting response
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_out_vld && i_out_stall))
        else $error("input stalled without a waiting response");

    // a held pipeline keeps its occupancy
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |=> ($stable(r_vld0) && $stable(vld[NumSteps])))
        else $error("pipeline moved while stalled");

    // a from-word request leaves decode already final
    a_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld0 && r_tag == OpFromWord) |-> r_lane0.fin)
        else $error("from-word request not final after decode");

endmodule

// File: hw/rtl/tffc_step.sv
`timescale 1ns / 1ps
// One registered scaling step of the to-word conversion: round, test, widen shift.
// Depends on tffc_pkg.
module tffc_step import tffc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_vld,
    input  t_lane i_lane,
    output logic  o_vld,
    output t_lane o_lane
);

    logic               r_vld;
    t_lane              r_lane;
    t_lane              n_lane;
    logic [52:0]        sh;
    logic [22:0]        rr;
    logic signed [12:0] xx;
    logic signed [12:0] room;
    logic [5:0]         g;
    logic [5:0]         nk;

    // round at the current shift and decide whether to carry on
    always_comb begin
        n_lane = i_lane;
        sh     = i_lane.m >> (6'd52 - {1'b0, i_lane.k});
        rr     = 23'((sh + 53'd1) >> 1);
        xx     = i_lane.e - 13'(i_lane.k);
        room   = xx - MinExp;
        g      = {3'd0, gaps_for(rr)};
        if (room < 13'(g)) g = room[5:0];
        nk     = {1'b0, i_lane.k} + g;
        if (!i_lane.fin && !i_lane.done) begin
            n_lane.r = rr;
            n_lane.x = xx;
            priority if (rr == Carry22) begin
                n_lane.r    = Bit21;
                n_lane.x    = xx + 13'sd1;
                n_lane.done = 1'b1;
            end else if (rr[21] || xx <= MinExp) begin
                n_lane.done = 1'b1;
            end else begin
                n_lane.k = (nk > {1'b0, MaxShift}) ? MaxShift : nk[4:0];
            end
        end
    end

    // advance when the pipeline moves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_vld  = r_vld;
    assign o_lane = r_lane;

endmodule

// File: test/tagged_float_format_converter_check.sv
`timescale 1ns / 1ps
// Checker for the tagged float converter: watches both channels and the tag
// register port, predicts each response and compares it. Depends on tffc_pkg.
module tagged_float_format_converter_check import tffc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  t_req        i_in,
    input  logic        i_in_stall,
    input  logic        i_out_valid,
    input  t_rsp        i_out,
    input  logic        i_out_stall,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    t_rsp       conv_expected_q[$];
    logic [2:0] tag_shadow;

    // free bits above the rounded mantissa
    function automatic int free_bits(input logic [31:0] r);
        logic [4:0] top;
        top = r[20:16];
        if (top == 5'd0) return 6;
        else if (top == 5'd1) return 5;
        else if (top < 5'd4) return 4;
        else if (top < 5'd8) return 3;
        else if (top < 5'd16) return 2;
        else return 1;
    endfunction

    function automatic logic [63:0] word_of(input logic [21:0] mant, input int ex,
                                            input logic msign, input logic [2:0] tag);
        logic [31:0] w;
        int          mag;
        mag = (ex < 0) ? -ex : ex;
        w = {msign, (ex < 0), mant, mag[4:0], tag};
        return {32'd0, w};
    endfunction

    // binary64 to tagged word
    function automatic t_rsp predict_to_word(input logic [63:0] bits, input logic [2:0] tag);
        t_rsp        rs;
        logic        msign;
        logic [10:0] bexp;
        logic [51:0] frac;
        logic [63:0] m;
        logic [31:0] r;
        int          e, k, x, room, g;
        bexp  = bits[62:52];
        frac  = bits[51:0];
        msign = bits[63];
        rs.overflow = 1'b0;
        if (bexp == 11'h7ff) begin
            rs.overflow = 1'b1;
            if (frac != 0) msign = 1'b0;
            rs.result = word_of(22'h3fffff, 31, msign, tag);
            return rs;
        end
        if (bexp == 0) begin
            if (frac == 0) msign = 1'b0;
            rs.result = word_of(22'd0, 0, msign, tag);
            return rs;
        end
        e = int'(bexp) - 1022;
        if (e <= -32) begin
            rs.result = word_of(22'd0, 0, msign, tag);
            return rs;
        end
        m = {11'd0, 1'b1, frac};
        k = 0;
        forever begin
            r = 32'((m + (64'd1 << (52 - k))) >> (53 - k));
            x = e - k;
            if (r == 32'h400000) begin
                r = 32'h200000;
                x = x + 1;
                break;
            end
            if (r[21] || x <= -31) break;
            room = x + 31;
            g = free_bits(r);
            k += (room < g) ? room : g;
            if (k > 22) k = 22;
        end
        if (x > 31) begin
            rs.overflow = 1'b1;
            rs.result = word_of(22'h3fffff, 31, msign, tag);
        end else begin
            rs.result = word_of(r[21:0], x, msign, tag);
        end
        return rs;
    endfunction

    // tagged word to binary64, exact
    function automatic t_rsp predict_from_word(input logic [63:0] op);
        t_rsp        rs;
        logic [21:0] mant;
        logic [63:0] wide;
        int          ex, p;
        logic [10:0] bexp;
        mant = op[29:8];
        ex = int'(op[7:3]);
        if (op[30]) ex = -ex;
        rs.overflow = 1'b0;
        if (mant == 0) begin
            rs.result = {op[31], 63'd0};
            return rs;
        end
        p = 21;
        while (!mant[p]) p--;
        wide = 64'(mant) << (52 - p);
        bexp = 11'(p + ex + 1023);
        rs.result = {op[31], bexp, wide[51:0]};
        return rs;
    endfunction

    assign o_pending = conv_expected_q.size();

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            tag_shadow   <= TagReset;
            o_fail_count <= 0;
            o_checked    <= 0;
            conv_expected_q.delete();
        end else begin
            // track the tag register
            if (i_cfg_we) tag_shadow <= i_cfg_data;
            // compare each accepted response with the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                o_checked <= o_checked + 1;
                if (conv_expected_q.size() == 0) begin
                    $error("response with nothing outstanding: result %h", i_out.result);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = conv_expected_q.pop_front();
                    if (want.result !== i_out.result || want.overflow !== i_out.overflow)
                        o_fail_count <= o_fail_count + 1;
                    if (want.result !== i_out.result)
                        $error("result: expected %h actual %h", want.result, i_out.result);
                    if (want.overflow !== i_out.overflow)
                        $error("overflow: expected %b actual %b", want.overflow,
                               i_out.overflow);
                end
            end
            // predict each accepted request
            if (i_in_valid && !i_in_stall) begin
                if (i_in.opcode == OpToWord)
                    conv_expected_q.push_back(predict_to_word(i_in.operand, tag_shadow));
                else
                    conv_expected_q.push_back(predict_from_word(i_in.operand));
            end
        end
    end

endmodule

// File: test/tagged_float_format_converter_test.sv
`timescale 1ns / 1ps
// Testbench top for the tagged float converter: clock, reset, request and
// stall generation, tag phases and verdict. Depends on tffc_pkg and the checker.
module tagged_float_format_converter_test;
    import tffc_pkg::*;

    localparam int CycleLimit = 400000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    t_req       i_in;
    logic       o_in_stall;
    logic       o_out_valid;
    t_rsp       o_out;
    logic       i_out_stall;
    logic       i_cfg_we;
    logic [2:0] i_cfg_data;
    int         fail_count, pending, checked, cycles, sent;
    logic       hold_off_req;

    tagged_float_format_converter u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid), .i_in(i_in),
        .o_in_stall(o_in_stall), .o_out_valid(o_out_valid), .o_out(o_out),
        .i_out_stall(i_out_stall), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    tagged_float_format_converter_check u_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid), .i_in(i_in),
        .i_in_stall(o_in_stall), .i_out_valid(o_out_valid), .i_out(o_out),
        .i_out_stall(i_out_stall), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending), .o_checked(checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // mostly back to back, sometimes short, rarely long
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(99);
        if (pick < 65) return 0;
        else if (pick < 95) return $urandom_range(3, 1);
        else return $urandom_range(40, 10);
    endfunction

    // abort on a runaway run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver stall: random gaps, plus one long hold-off on request
    initial begin
        int   n, hold_cnt;
        logic held;
        held = 1'b0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req && !held) begin
                hold_cnt = 0;
                while (hold_cnt < 300) begin
                    i_out_stall <= 1'b1;
                    @(posedge i_clk);
                    hold_cnt++;
                end
                held = 1'b1;
            end
            n = idle_len();
            i_out_stall <= (n != 0);
            repeat (n) @(posedge i_clk);
            i_out_stall <= 1'b0;
        end
    end

    // offer one request and hold it until taken, then maybe drop valid
    task automatic send_req(input logic op, input logic [63:0] operand);
        int gap;
        i_in_valid <= 1'b1;
        i_in       <= '{opcode: op, operand: operand};
        do @(posedge i_clk); while (o_in_stall);
        sent++;
        gap = idle_len();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // drain the pipeline, then write the tag
    task automatic set_tag(input logic [2:0] tag);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= tag;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // random double, weighted toward the interesting exponent range
    function automatic logic [63:0] rand_double();
        logic [63:0] v;
        int          pick;
        v = {$urandom, $urandom};
        pick = $urandom_range(99);
        if (pick < 60) v[62:52] = 11'($urandom_range(1022 + 34, 1022 - 34));
        else if (pick < 68) v[62:52] = 11'h7ff;
        else if (pick < 74) v[62:52] = 11'h000;
        else if (pick < 80) begin
            v[62:52] = 11'($urandom_range(1022 + 32, 1022 - 32));
            v[51:20] = '1;
        end else if (pick < 84) v[51:0] = '0;
        return v;
    endfunction

    initial begin
        logic [2:0] phase_tags[4];
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in         = '0;
        i_cfg_we     = 1'b0;
        i_cfg_data   = '0;
        sent         = 0;
        hold_off_req = 1'b0;
        phase_tags   = '{3'd0, 3'd7, 3'd5, 3'd3};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zeros, subnormal, tiny edge, specials, saturation, carry
        send_req(OpToWord, 64'h0000000000000000);
        send_req(OpToWord, 64'h8000000000000000);
        send_req(OpToWord, 64'h800fffffffffffff);
        send_req(OpToWord, 64'h3df0000000000000);
        send_req(OpToWord, 64'hbe00000000000001);
        send_req(OpToWord, 64'h3e0fffffffffffff);
        send_req(OpToWord, 64'h3ff0000000000000);
        send_req(OpToWord, 64'h3fffffffffffffff);
        send_req(OpToWord, 64'h41dfffffffffffff);
        send_req(OpToWord, 64'h41e0000000000000);
        send_req(OpToWord, 64'h7fefffffffffffff);
        send_req(OpToWord, 64'h7ff0000000000000);
        send_req(OpToWord, 64'hfff0000000000000);
        send_req(OpToWord, 64'hfff8000000000001);
        send_req(OpToWord, 64'h0010000000000000);
        send_req(OpFromWord, 64'hffffffff80000007);
        send_req(OpFromWord, 64'h0000000000000000);
        send_req(OpFromWord, 64'h3fffffff);
        send_req(OpFromWord, 64'hffffffffffffffff);
        send_req(OpFromWord, 64'h00000100);
        send_req(OpFromWord, 64'h4000017a);

        // random phases, one per tag setting
        foreach (phase_tags[p]) begin
            set_tag(phase_tags[p]);
            if (p == 1) hold_off_req = 1'b1;
            repeat (320) begin
                if ($urandom_range(1))
                    send_req(OpToWord, rand_double());
                else
                    send_req(OpFromWord, {$urandom, $urandom});
            end
        end

        // drain and let the pipeline settle
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Sent %0d requests in both directions over five tag settings;", sent);
        $display("checked %0d responses, %0d failures.", checked, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
